### hw/rtl/complex_arith_unit_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("complex_arith_unit: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("complex_arith_unit: next-cycle check failed");

`endif

### hw/rtl/cau_pkg.sv
package cau_pkg;

  localparam int Q_W          = 16;
  localparam int FRAC_BITS_DEF = 12;
  // Quotient bits kept by the divider: enough to tell any overflow of 16 bits.
  localparam int Q_BITS       = 17;
  localparam int SQ_BITS      = 16;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_MAG  = 3'd5;
  localparam logic [2:0] OP_LESS = 3'd6;
  localparam logic [2:0] OP_GRTR = 3'd7;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // Data carried through the divide and square-root steps.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] res_r;
    logic signed [15:0] res_i;
    logic [1:0]         status;
    logic               cmp;
    logic               dz;
    logic               sgn_r;
    logic               sgn_i;
    logic               ovf_r;
    logic               ovf_i;
    logic [31:0]        den;
    logic [31:0]        num_r;
    logic [31:0]        num_i;
    logic [31:0]        rem_r;
    logic [31:0]        rem_i;
    logic [16:0]        q_r;
    logic [16:0]        q_i;
    logic [31:0]        sq_v;
    logic [17:0]        sq_rem;
    logic [15:0]        sq_root;
  } pipe_t;

  // Saturates a wide signed value to 16 bits; the top bit flags saturation.
  function automatic logic [16:0] clamp34(input logic signed [33:0] x);
    logic [16:0] r;
    if (x > 34'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (x < -34'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, x[15:0]};
    end
    return r;
  endfunction

endpackage

### hw/rtl/cau_step.sv
// One pipeline step: one quotient bit for both division parts and, where BIT
// is below SQ_BITS, one root bit for the square root.
module cau_step #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int BIT       = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  cau_pkg::pipe_t din,
  output logic           vout,
  output cau_pkg::pipe_t dout
);

  localparam bit DUSE = BIT >= FRAC_BITS;
  localparam int DIDX = DUSE ? BIT - FRAC_BITS : 0;
  localparam bit SUSE = BIT < cau_pkg::SQ_BITS;
  localparam int SIDX = SUSE ? 2 * BIT + 1 : 1;

  cau_pkg::pipe_t d_next;
  logic           db_r;
  logic           db_i;
  logic [32:0]    tr_r;
  logic [32:0]    tr_i;
  logic [19:0]    srem;
  logic [19:0]    strial;

  always_comb begin
    d_next = din;
    // Bring down the next dividend bit; dividend is the numerator shifted up.
    db_r = DUSE ? din.num_r[DIDX] : 1'b0;
    db_i = DUSE ? din.num_i[DIDX] : 1'b0;
    tr_r = {din.rem_r, db_r};
    tr_i = {din.rem_i, db_i};
    if (tr_r >= {1'b0, din.den}) begin
      d_next.rem_r = 32'(tr_r - {1'b0, din.den});
      d_next.q_r   = {din.q_r[15:0], 1'b1};
    end else begin
      d_next.rem_r = tr_r[31:0];
      d_next.q_r   = {din.q_r[15:0], 1'b0};
    end
    if (tr_i >= {1'b0, din.den}) begin
      d_next.rem_i = 32'(tr_i - {1'b0, din.den});
      d_next.q_i   = {din.q_i[15:0], 1'b1};
    end else begin
      d_next.rem_i = tr_i[31:0];
      d_next.q_i   = {din.q_i[15:0], 1'b0};
    end
    // Square root: take the next bit pair and try the trial subtrahend.
    srem   = {din.sq_rem, din.sq_v[SIDX -: 2]};
    strial = {2'b00, din.sq_root, 2'b01};
    if (SUSE) begin
      if (srem >= strial) begin
        d_next.sq_rem  = 18'(srem - strial);
        d_next.sq_root = {din.sq_root[14:0], 1'b1};
      end else begin
        d_next.sq_rem  = srem[17:0];
        d_next.sq_root = {din.sq_root[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

### hw/rtl/complex_arith_unit.sv
// Channel | Direction | Handshake          | Beat contents
// in      | input     | in_valid/in_stall   | operation, a_real, a_imag, b_real, b_imag
// out     | output    | out_valid/out_stall | res_real, res_imag, magnitude, compare_true, status
//
// One beat is taken per cycle while the output is not stalled; each beat passes through:
// input register, products, sums, 17 divider/root steps, output register.
// The number of steps is set by the 17 quotient bits of the restoring divider.
// Reset clears only the valid bits; it takes effect at the next rising edge.
// A stall at the output with out_valid high freezes the whole pipeline and raises in_stall.
`include "complex_arith_unit_macros.svh"

module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] res_real,
  output logic signed [15:0] res_imag,
  output logic [15:0]        magnitude,
  output logic               compare_true,
  output logic [1:0]         status
);

  localparam int NSTEP = cau_pkg::Q_BITS;
  localparam int PRE   = NSTEP - FRAC_BITS;
  localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input register.
  logic               a_valid;
  logic [2:0]         a_op;
  logic signed [15:0] a_ar, a_ai, a_br, a_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op <= operation;
      a_ar <= a_real;
      a_ai <= a_imag;
      a_br <= b_real;
      a_bi <= b_imag;
    end
  end

  // Products, plus the results that need no multiplier.
  logic               b_valid;
  logic [2:0]         b_op;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir, p_aa_r, p_aa_i, p_bb_r, p_bb_i;
  logic signed [15:0] b_res_r, b_res_i;
  logic               b_sat;
  logic signed [33:0] s_r, s_i;
  logic [16:0]        c_r, c_i;

  always_comb begin
    unique case (a_op)
      cau_pkg::OP_ADD: begin
        s_r = 34'(a_ar) + 34'(a_br);
        s_i = 34'(a_ai) + 34'(a_bi);
      end
      cau_pkg::OP_SUB: begin
        s_r = 34'(a_ar) - 34'(a_br);
        s_i = 34'(a_ai) - 34'(a_bi);
      end
      cau_pkg::OP_CONJ: begin
        s_r = 34'(a_ar);
        s_i = 34'sd0 - 34'(a_ai);
      end
      default: begin
        s_r = '0;
        s_i = '0;
      end
    endcase
    c_r = cau_pkg::clamp34(s_r);
    c_i = cau_pkg::clamp34(s_i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op    <= a_op;
      p_rr    <= a_ar * a_br;
      p_ii    <= a_ai * a_bi;
      p_ri    <= a_ar * a_bi;
      p_ir    <= a_ai * a_br;
      p_aa_r  <= a_ar * a_ar;
      p_aa_i  <= a_ai * a_ai;
      p_bb_r  <= a_br * a_br;
      p_bb_i  <= a_bi * a_bi;
      b_res_r <= c_r[15:0];
      b_res_i <= c_i[15:0];
      b_sat   <= c_r[16] | c_i[16];
    end
  end

  // Sums: multiply result, division set-up, squared magnitudes, comparisons.
  cau_pkg::pipe_t     c_next;
  logic signed [33:0] m_r, m_i;
  logic [16:0]        mc_r, mc_i;
  logic signed [32:0] n_r, n_i;
  logic [31:0]        ma, mb;

  always_comb begin
    m_r  = (34'(p_rr) - 34'(p_ii) + HALF) >>> FRAC_BITS;
    m_i  = (34'(p_ri) + 34'(p_ir) + HALF) >>> FRAC_BITS;
    mc_r = cau_pkg::clamp34(m_r);
    mc_i = cau_pkg::clamp34(m_i);
    n_r  = 33'(p_rr) + 33'(p_ii);
    n_i  = 33'(p_ir) - 33'(p_ri);
    ma   = 32'(p_aa_r) + 32'(p_aa_i);
    mb   = 32'(p_bb_r) + 32'(p_bb_i);

    c_next        = '0;
    c_next.op     = b_op;
    c_next.sgn_r  = n_r[32];
    c_next.sgn_i  = n_i[32];
    c_next.num_r  = n_r[32] ? 32'(-n_r) : n_r[31:0];
    c_next.num_i  = n_i[32] ? 32'(-n_i) : n_i[31:0];
    c_next.den    = mb;
    c_next.dz     = mb == 32'd0;
    c_next.rem_r  = c_next.num_r >> PRE;
    c_next.rem_i  = c_next.num_i >> PRE;
    c_next.ovf_r  = c_next.rem_r >= mb;
    c_next.ovf_i  = c_next.rem_i >= mb;
    c_next.sq_v   = ma;
    unique case (b_op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
        c_next.res_r  = b_res_r;
        c_next.res_i  = b_res_i;
        c_next.status = b_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_MUL: begin
        c_next.res_r  = mc_r[15:0];
        c_next.res_i  = mc_i[15:0];
        c_next.status = (mc_r[16] | mc_i[16]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_LESS: c_next.cmp = ma < mb;
      cau_pkg::OP_GRTR: c_next.cmp = ma > mb;
      default: c_next.status = cau_pkg::ST_OK;
    endcase
  end

  logic           sv [0:NSTEP];
  cau_pkg::pipe_t sd [0:NSTEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= c_next;
    end
  end

  // Divider and square-root steps, most significant bit first.
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    cau_step #(
      .FRAC_BITS(FRAC_BITS),
      .BIT      (NSTEP - 1 - k)
    ) u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .vin (sv[k]),
      .din (sd[k]),
      .vout(sv[k+1]),
      .dout(sd[k+1])
    );
  end

  // Final signed quotient with saturation; top bit flags saturation.
  function automatic logic [16:0] quot_fix(input logic sgn, input logic ovf,
                                           input logic [16:0] q);
    logic [16:0] r;
    if (ovf) begin
      r = {1'b1, sgn ? 16'h8000 : 16'h7FFF};
    end else if (!sgn) begin
      r = (q > 17'd32767) ? {1'b1, 16'h7FFF} : {1'b0, q[15:0]};
    end else begin
      r = (q > 17'd32768) ? {1'b1, 16'h8000} : {1'b0, 16'(~q + 17'd1)};
    end
    return r;
  endfunction

  cau_pkg::pipe_t f;
  logic [16:0]    fq_r, fq_i;
  logic signed [15:0] o_r, o_i;
  logic [15:0]    o_mag;
  logic [1:0]     o_st;

  assign f = sd[NSTEP];

  always_comb begin
    fq_r  = quot_fix(f.sgn_r, f.ovf_r, f.q_r);
    fq_i  = quot_fix(f.sgn_i, f.ovf_i, f.q_i);
    o_r   = f.res_r;
    o_i   = f.res_i;
    o_st  = f.status;
    o_mag = '0;
    unique case (f.op)
      cau_pkg::OP_DIV: begin
        if (f.dz) begin
          o_r  = '0;
          o_i  = '0;
          o_st = cau_pkg::ST_DZ;
        end else begin
          o_r  = fq_r[15:0];
          o_i  = fq_i[15:0];
          o_st = (fq_r[16] | fq_i[16]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::OP_MAG: o_mag = f.sq_root;
      default: o_mag = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_real     <= o_r;
      res_imag     <= o_i;
      magnitude    <= o_mag;
      compare_true <= f.cmp;
      status       <= o_st;
    end
  end

  // A division by zero always returns zero.
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && status == cau_pkg::ST_DZ, res_real == 16'sd0 && res_imag == 16'sd0)
  // Comparison and magnitude beats carry no other result; checked here for true comparisons.
  `CAU_ASSERT_IMP(a_cmp_clean, out_valid && compare_true, magnitude == 16'd0 && status == cau_pkg::ST_OK && res_real == 16'sd0)
  // An accepted beat occupies the input register on the next cycle.
  `CAU_ASSERT_NXT(a_accept, in_valid && !in_stall, a_valid)

endmodule
